FILE: src/esdt_pkg.sv
// ----------------------------------------------------------------------------
// esdt_pkg: shared types and constants for the seconds-to-date converter
// Command/status structs between controller and datapath, reciprocal
// constants for the day and time-of-day split, and the month length table.
// ----------------------------------------------------------------------------
package esdt_pkg;

  localparam longint unsigned SECS_PER_DAY  = 86400;
  localparam longint unsigned SECS_PER_HOUR = 3600;
  localparam longint unsigned SECS_PER_MIN  = 60;
  localparam int unsigned     BASE_YEAR     = 2000;

  localparam int unsigned SEC_W  = 32;
  localparam int unsigned DAYS_W = 16;  // days  < 2^16
  localparam int unsigned TOD_W  = 17;  // seconds of a day  < 2^17
  localparam int unsigned HREM_W = 12;  // seconds of an hour < 2^12

  // floor(x / d) = (x * RECIP) >> SHIFT over the whole operand range.
  // Days: (secs >> 7) / 675, hours: (tod >> 4) / 225, minutes: (rem >> 2) / 15.
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // 2^35 / 675, rounded up
  localparam int unsigned DAY_SHIFT  = 35;
  localparam logic [13:0] HOUR_RECIP = 14'd9321;      // 2^21 / 225, rounded up
  localparam int unsigned HOUR_SHIFT = 21;
  localparam logic [10:0] MIN_RECIP  = 11'd1093;      // 2^14 / 15, rounded up
  localparam int unsigned MIN_SHIFT  = 14;

  localparam logic [3:0] MON_FEB = 4'd1;
  localparam logic [3:0] MON_DEC = 4'd11;

  typedef struct packed {
    logic load_secs;
    logic calc_days;
    logic calc_tod;
    logic calc_hour;
    logic calc_hrem;
    logic calc_min;
    logic calc_sec;
    logic year_step;
    logic month_step;
  } dp_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } dp_sts_t;

  function automatic logic [4:0] month_length(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: src/esdt_dp.sv
// ----------------------------------------------------------------------------
// esdt_dp: datapath of the seconds-to-date converter
// Reciprocal-multiply split, year/month subtract loops, leap tracking.
// ----------------------------------------------------------------------------
module esdt_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [31:0]               elapsed_seconds,
  input  esdt_pkg::dp_cmd_t         cmd,
  output esdt_pkg::dp_sts_t         sts,
  output logic [11:0]               cal_year,
  output logic [3:0]                cal_month,
  output logic [4:0]                cal_day,
  output logic [4:0]                clock_hour,
  output logic [5:0]                clock_minute,
  output logic [5:0]                clock_second
);
  import esdt_pkg::*;

  logic [SEC_W-1:0]  secs;
  logic [DAYS_W-1:0] days;
  logic [TOD_W-1:0]  tod;
  logic [4:0]        hour;
  logic [HREM_W-1:0] hrem;
  logic [5:0]        minute;
  logic [5:0]        second;
  logic [11:0]       year;
  logic [1:0]        y4;
  logic [6:0]        y100;
  logic [8:0]        y400;
  logic [3:0]        mon;

  logic [50:0]       day_prod;
  logic [SEC_W-1:0]  day_base;
  logic [SEC_W-1:0]  tod_full;
  logic [26:0]       hour_prod;
  logic [TOD_W-1:0]  hour_base;
  logic [TOD_W-1:0]  hrem_full;
  logic [20:0]       min_prod;
  logic [HREM_W-1:0] min_base;
  logic [HREM_W-1:0] sec_full;
  logic              leap;
  logic [8:0]        ylen;
  logic [4:0]        mlen;

  // one registered step each: quotient by reciprocal, then remainder
  assign day_prod  = 51'(secs[31:7]) * 51'(DAY_RECIP);
  assign day_base  = SEC_W'(days) * SEC_W'(SECS_PER_DAY);
  assign tod_full  = secs - day_base;
  assign hour_prod = 27'(tod[16:4]) * 27'(HOUR_RECIP);
  assign hour_base = TOD_W'(hour) * TOD_W'(SECS_PER_HOUR);
  assign hrem_full = tod - hour_base;
  assign min_prod  = 21'(hrem[11:2]) * 21'(MIN_RECIP);
  assign min_base  = HREM_W'(minute) * HREM_W'(SECS_PER_MIN);
  assign sec_full  = hrem - min_base;

  assign leap = ((y4 == 2'd0) && (y100 != 7'd0)) || (y400 == 9'd0);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_length(mon, leap);

  assign sts.year_done  = (days < DAYS_W'(ylen));
  assign sts.month_done = (mon == MON_DEC) || (days < DAYS_W'(mlen));

  always_ff @(posedge clk) begin
    if (cmd.load_secs) begin
      secs <= elapsed_seconds;
    end

    if (cmd.calc_days) begin
      days <= day_prod[DAY_SHIFT +: DAYS_W];
    end else if (cmd.year_step) begin
      days <= days - DAYS_W'(ylen);
    end else if (cmd.month_step) begin
      days <= days - DAYS_W'(mlen);
    end

    if (cmd.calc_tod) begin
      tod <= tod_full[TOD_W-1:0];
    end
    if (cmd.calc_hour) begin
      hour <= hour_prod[HOUR_SHIFT +: 5];
    end
    if (cmd.calc_hrem) begin
      hrem <= hrem_full[HREM_W-1:0];
    end
    if (cmd.calc_min) begin
      minute <= min_prod[MIN_SHIFT +: 6];
    end
    if (cmd.calc_sec) begin
      second <= sec_full[5:0];
    end
  end

  // year and leap-cycle counters, restarted for each transaction
  always_ff @(posedge clk) begin
    if (rst || cmd.load_secs) begin
      year <= 12'(BASE_YEAR);
      y4   <= 2'(BASE_YEAR % 4);
      y100 <= 7'(BASE_YEAR % 100);
      y400 <= 9'(BASE_YEAR % 400);
      mon  <= '0;
    end else begin
      if (cmd.year_step) begin
        year <= year + 12'd1;
        y4   <= y4 + 2'd1;
        y100 <= (y100 == 7'd99)  ? 7'd0 : y100 + 7'd1;
        y400 <= (y400 == 9'd399) ? 9'd0 : y400 + 9'd1;
      end
      if (cmd.month_step) begin
        mon <= mon + 4'd1;
      end
    end
  end

  assign cal_year     = year;
  assign cal_month    = mon + 4'd1;
  assign cal_day      = days[4:0] + 5'd1;
  assign clock_hour   = hour;
  assign clock_minute = minute;
  assign clock_second = second;

  a_mon_range: assert property (@(posedge clk) disable iff (rst)
    cmd.month_step |=> (mon <= MON_DEC))
    else $error("month index passed December");

  a_feb_leap: assert property (@(posedge clk) disable iff (rst)
    (mon == MON_FEB && leap) |-> (mlen == 5'd29))
    else $error("leap February not 29 days");

  a_tod_range: assert property (@(posedge clk) disable iff (rst)
    cmd.calc_hrem |-> (tod < TOD_W'(SECS_PER_DAY)))
    else $error("time of day past one day");

endmodule

FILE: src/esdt_ctrl.sv
// ----------------------------------------------------------------------------
// esdt_ctrl: sequencer of the seconds-to-date converter
// Steps the day and time-of-day split, then the year and month loops, then
// strobes.
// ----------------------------------------------------------------------------
module esdt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              valid,
  output esdt_pkg::dp_cmd_t cmd,
  input  esdt_pkg::dp_sts_t sts
);
  import esdt_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_DAYS  = 10'b0000000010,
    ST_TOD   = 10'b0000000100,
    ST_HOUR  = 10'b0000001000,
    ST_HREM  = 10'b0000010000,
    ST_MIN   = 10'b0000100000,
    ST_SEC   = 10'b0001000000,
    ST_YEAR  = 10'b0010000000,
    ST_MONTH = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load_secs = 1'b1;
          state_next    = ST_DAYS;
        end
      end
      ST_DAYS: begin
        cmd.calc_days = 1'b1;
        state_next    = ST_TOD;
      end
      ST_TOD: begin
        cmd.calc_tod = 1'b1;
        state_next   = ST_HOUR;
      end
      ST_HOUR: begin
        cmd.calc_hour = 1'b1;
        state_next    = ST_HREM;
      end
      ST_HREM: begin
        cmd.calc_hrem = 1'b1;
        state_next    = ST_MIN;
      end
      ST_MIN: begin
        cmd.calc_min = 1'b1;
        state_next   = ST_SEC;
      end
      ST_SEC: begin
        cmd.calc_sec = 1'b1;
        state_next   = ST_YEAR;
      end
      ST_YEAR: begin
        if (sts.year_done) begin
          state_next = ST_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      ST_MONTH: begin
        if (sts.month_done) begin
          state_next = ST_DONE;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy  = (state != ST_IDLE);
  assign valid = (state == ST_DONE);

  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !valid))
    else $error("accepted transaction did not start");

  a_strobe: assert property (@(posedge clk) disable iff (rst)
    valid |=> (!valid && !busy))
    else $error("result strobe longer than one cycle");

  a_year_step: assert property (@(posedge clk) disable iff (rst)
    cmd.year_step |-> !sts.year_done)
    else $error("year step past the final year");

  a_month_step: assert property (@(posedge clk) disable iff (rst)
    cmd.month_step |-> !sts.month_done)
    else $error("month step past the final month");

endmodule

FILE: src/epoch_seconds_to_datetime_top.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_datetime_top: seconds since 2000-01-01 to calendar date
// Converts a 32-bit seconds count into year, month, day, hour, minute and
// second with the full Gregorian leap rule.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   ---------------------  ---------------------------------------
//  input     start, busy            elapsed_seconds[31:0]
//  result    valid (1-cycle strobe) cal_year, cal_month, cal_day,
//                                   clock_hour, clock_minute, clock_second
//
//  A transaction is taken when start is high and busy is low. After the
//  accepting edge, states for days, time of day, hour, hour remainder,
//  minute and second split the count by reciprocal multiplication; then
//  the year loop, one year per cycle, walks the whole years after 2000
//  (0..136) and dominates, and the month loop walks the month index (0..11).
//  The longest conversion is for late December 2135. A new transaction is
//  taken only once busy drops after the valid strobe. Synchronous reset
//  returns the sequencer to idle. The receiver cannot stall: valid marks
//  each result for a single cycle, and the fields hold until the next one.
//
module epoch_seconds_to_datetime_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] elapsed_seconds,
  output logic        valid,
  output logic [11:0] cal_year,
  output logic [3:0]  cal_month,
  output logic [4:0]  cal_day,
  output logic [4:0]  clock_hour,
  output logic [5:0]  clock_minute,
  output logic [5:0]  clock_second
);
  import esdt_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: day and time split, then year and month loops, then strobe
  esdt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .valid (valid),
    .cmd   (cmd),
    .sts   (sts)
  );

  // datapath: result fields hold from the strobe until the next transaction
  esdt_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .elapsed_seconds (elapsed_seconds),
    .cmd             (cmd),
    .sts             (sts),
    .cal_year        (cal_year),
    .cal_month       (cal_month),
    .cal_day         (cal_day),
    .clock_hour      (clock_hour),
    .clock_minute    (clock_minute),
    .clock_second    (clock_second)
  );

endmodule

FILE: tb/sv/calendar_checker.sv
// ----------------------------------------------------------------------------
// calendar_checker: predicts and checks dates from the seconds converter
// Watches the command and result channels of the converter. Turns every
// accepted timestamp into the expected calendar date and time of day. Checks
// each result strobe, field by field, against the oldest pending date.
// ----------------------------------------------------------------------------
module calendar_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] elapsed_seconds,
  input  logic        valid,
  input  logic [11:0] cal_year,
  input  logic [3:0]  cal_month,
  input  logic [4:0]  cal_day,
  input  logic [4:0]  clock_hour,
  input  logic [5:0]  clock_minute,
  input  logic [5:0]  clock_second,
  output int          mismatches,
  output int          pending_count,
  output int          compared
);

  import esdt_pkg::*;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  // Month lengths of a common year, January first.
  int unsigned month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  calendar_t expected_dates [$];
  calendar_t oldest_date;

  initial begin
    mismatches    = 0;
    pending_count = 0;
    compared      = 0;
  end

  function automatic bit leap_rule_holds(input int unsigned year);
    return ((year % 4) == 0 && (year % 100) != 0) || ((year % 400) == 0);
  endfunction

  function automatic calendar_t seconds_to_calendar(input logic [31:0] secs);
    int unsigned days;
    int unsigned tod;
    int unsigned year;
    int unsigned mon;
    int unsigned mlen;
    calendar_t   date;
    days = 32'(secs / SECS_PER_DAY);
    tod  = 32'(secs % SECS_PER_DAY);
    year = BASE_YEAR;
    mon  = 0;
    // Strip whole years first, then whole months of the final year.
    while (days >= (leap_rule_holds(year) ? 366 : 365)) begin
      days -= leap_rule_holds(year) ? 366 : 365;
      year++;
    end
    while (mon < 11) begin
      mlen = (mon == 1 && leap_rule_holds(year)) ? 29 : month_len[mon];
      if (days < mlen) break;
      days -= mlen;
      mon++;
    end
    date.year   = 12'(year);
    date.month  = 4'(mon + 1);
    date.day    = 5'(days + 1);
    date.hour   = 5'(tod / SECS_PER_HOUR);
    date.minute = 6'((tod % SECS_PER_HOUR) / SECS_PER_MIN);
    date.second = 6'(tod % SECS_PER_MIN);
    return date;
  endfunction

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // Retire a result before queueing a new transaction from the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (valid) begin
        if (expected_dates.size() == 0) begin
          $error("result %0d-%0d-%0d with no timestamp pending",
                 cal_year, cal_month, cal_day);
          mismatches++;
        end else begin
          oldest_date = expected_dates.pop_front();
          compare_field("cal_year",     oldest_date.year,   cal_year);
          compare_field("cal_month",    oldest_date.month,  cal_month);
          compare_field("cal_day",      oldest_date.day,    cal_day);
          compare_field("clock_hour",   oldest_date.hour,   clock_hour);
          compare_field("clock_minute", oldest_date.minute, clock_minute);
          compare_field("clock_second", oldest_date.second, clock_second);
          compared++;
        end
      end
      if (start && !busy) begin
        expected_dates.push_back(seconds_to_calendar(elapsed_seconds));
      end
      pending_count = expected_dates.size();
    end
  end

endmodule

FILE: tb/sv/epoch_seconds_to_datetime_top_test.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_datetime_top_test: regression for the seconds converter
// Sends directed timestamps at the calendar boundaries, then random ones:
// plain 32-bit values, values just around month and year edges, random dates
// and values near the top of the range. Random gaps on the command side,
// some counted from idle, with bursts of back-to-back transactions. A
// separate checker predicts every date and compares each result strobe.
// ----------------------------------------------------------------------------
module epoch_seconds_to_datetime_top_test;

  localparam int RANDOM_ITEMS   = 1100;
  localparam int IDLE_LIMIT     = 2000;  // cycles with no transaction at all
  localparam int DRAIN_CYCLES   = 200;   // longer than the longest conversion
  localparam int FIRST_YEAR     = 2000;
  localparam int LAST_FULL_YEAR = 2135;  // 2136 only reaches early February

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [31:0] elapsed_seconds = '0;
  logic        busy;
  logic        valid;
  logic [11:0] cal_year;
  logic [3:0]  cal_month;
  logic [4:0]  cal_day;
  logic [4:0]  clock_hour;
  logic [5:0]  clock_minute;
  logic [5:0]  clock_second;

  int mismatches;
  int pending_count;
  int compared;
  int sent = 0;
  int idle_cycles = 0;
  bit burst = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  epoch_seconds_to_datetime_top dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .elapsed_seconds (elapsed_seconds),
    .valid           (valid),
    .cal_year        (cal_year),
    .cal_month       (cal_month),
    .cal_day         (cal_day),
    .clock_hour      (clock_hour),
    .clock_minute    (clock_minute),
    .clock_second    (clock_second)
  );

  calendar_checker calendar_check (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .elapsed_seconds (elapsed_seconds),
    .valid           (valid),
    .cal_year        (cal_year),
    .cal_month       (cal_month),
    .cal_day         (cal_day),
    .clock_hour      (clock_hour),
    .clock_minute    (clock_minute),
    .clock_second    (clock_second),
    .mismatches      (mismatches),
    .pending_count   (pending_count),
    .compared        (compared)
  );

  // Watchdog: count cycles in which neither a command nor a result moves.
  // A hung sequencer or a lost strobe ends the run here.
  always @(posedge clk) begin
    if ((start && !busy) || valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("epoch_seconds_to_datetime_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Days in a month of a given year, Gregorian leap rule for February.
  function automatic int month_length_of(input int year, input int month);
    bit leap;
    leap = ((year % 4) == 0 && (year % 100) != 0) || ((year % 400) == 0);
    case (month)
      2:             return leap ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  // Build a timestamp from a calendar date; used to aim at the edges.
  function automatic logic [31:0] date_to_seconds(input int year, input int month,
                                                  input int day, input int hour,
                                                  input int minute, input int second);
    longint unsigned days;
    days = 0;
    for (int y = FIRST_YEAR; y < year; y++) days += (month_length_of(y, 2) == 29) ? 366 : 365;
    for (int m = 1; m < month; m++) days += month_length_of(year, m);
    days += day - 1;
    return 32'(days * 86400 + hour * 3600 + minute * 60 + second);
  endfunction

  // Issue one transaction. Entered at a rising edge; returns at the edge
  // that accepted the command. Start stays high across back-to-back items,
  // so it is never lowered and raised within one time step.
  task automatic send_timestamp(input logic [31:0] secs);
    int gap;
    bit from_idle;
    gap       = burst ? 0 : $urandom_range(0, 8);
    from_idle = !burst && ($urandom_range(0, 1) == 1);
    if (from_idle || gap != 0) begin
      start           <= 1'b0;
      elapsed_seconds <= $urandom();  // junk while start is low
    end
    // Optionally wait for the block to go idle, so the gap lands after busy
    // drops rather than inside a conversion.
    if (from_idle) begin
      do @(negedge clk); while (busy);
      @(posedge clk);
    end
    repeat (gap) @(posedge clk);
    start           <= 1'b1;
    elapsed_seconds <= secs;
    // Busy only moves at rising edges: the value at the falling edge is the
    // one the next rising edge sees.
    do @(negedge clk); while (busy);
    @(posedge clk);
    sent++;
  endtask

  // Random timestamp, mostly aimed at the places where the year and month
  // walk can go wrong.
  function automatic logic [31:0] random_timestamp();
    int pick;
    int year;
    int month;
    pick  = $urandom_range(0, 99);
    year  = $urandom_range(FIRST_YEAR, LAST_FULL_YEAR);
    month = $urandom_range(1, 12);
    if (pick < 40) begin
      return $urandom();
    end else if (pick < 75) begin
      // Straddle midnight at the start of a month, a couple of seconds each way.
      return date_to_seconds(year, month, 1, 0, 0, 0) + $urandom_range(0, 4) - 32'd2;
    end else if (pick < 90) begin
      return date_to_seconds(year, month, $urandom_range(1, month_length_of(year, month)),
                             $urandom_range(0, 23), $urandom_range(0, 59),
                             $urandom_range(0, 59));
    end else begin
      // Longest year walks, up into 2136.
      return 32'hFFFF_FFFF - $urandom_range(0, 200_000_000);
    end
  endfunction

  initial begin
    logic [31:0] directed [$];

    // Hold reset, then release it on a rising edge.
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: field rollovers, leap and century rules, range extremes.
    directed = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3600, 32'd86399, 32'd86400,
                 date_to_seconds(2000, 2, 28, 23, 59, 59),
                 date_to_seconds(2000, 2, 29, 0, 0, 0),
                 date_to_seconds(2000, 2, 29, 23, 59, 59),
                 date_to_seconds(2000, 3, 1, 0, 0, 0),
                 date_to_seconds(2000, 12, 31, 23, 59, 59),
                 date_to_seconds(2001, 1, 1, 0, 0, 0),
                 date_to_seconds(2001, 2, 28, 23, 59, 59),
                 date_to_seconds(2001, 3, 1, 0, 0, 0),
                 date_to_seconds(2100, 2, 28, 23, 59, 59),
                 date_to_seconds(2100, 3, 1, 0, 0, 0),
                 date_to_seconds(2104, 2, 29, 12, 30, 30),
                 date_to_seconds(2135, 12, 31, 23, 59, 59),
                 date_to_seconds(2136, 1, 1, 0, 0, 0),
                 32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'hFFFF_FFFF};
    foreach (directed[i]) send_timestamp(directed[i]);

    // Random part; every 150 items a stretch of 25 back-to-back transactions.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      burst = (i % 150) < 25;
      send_timestamp(random_timestamp());
    end
    start <= 1'b0;

    // Drain: wait for the last date, then give a stray strobe time to show.
    do @(negedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d timestamps (%0d directed), %0d dates compared",
             sent, directed.size(), compared);
    $display("range covered from 2000-01-01 through 2136, gaps 0..8 and bursts");
    if (mismatches == 0 && pending_count == 0) begin
      $display("epoch_seconds_to_datetime_top regression: pass");
    end else begin
      $display("%0d mismatches, %0d dates never returned", mismatches, pending_count);
      $display("epoch_seconds_to_datetime_top regression: fail");
    end
    $finish;
  end

endmodule
